FILE: src/iptl_pkg.sv
// ----------------------------------------------------------------------------
// iptl_pkg: shared types and constants of the IP permission table
// Request/response payloads, entry layout, opcodes, FSM states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iptl_pkg;

   localparam int ENTRIES  = 1024;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int CNT_W    = IDX_W + 1;
   localparam int MEM_AW   = IDX_W + 1;
   localparam int MEM_DEPTH = 2 * (1 << IDX_W);
   localparam int COUNT_W  = 11;

   localparam logic [2:0] PERM_RW = 3'b011;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_COMMIT = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_MISS   = 2'd1,
      ST_FULL   = 2'd2,
      ST_REJECT = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] ip_address;
      logic [2:0]  permission_bits;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [2:0]         granted;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [2:0]  perm;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_MISSED,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_FINISH
   } state_type;

   typedef enum logic [3:0] {
      K_INS_NEW,
      K_INS_MERGE,
      K_FULL,
      K_REJECT,
      K_COMMIT,
      K_HIT,
      K_MISS,
      K_EMPTY,
      K_NOP
   } kind_type;

   typedef struct packed {
      logic     load;
      logic     rd_mid;
      logic     step;
      logic     rd_shift;
      logic     wr_shift;
      logic     finish;
      kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic is_insert;
      logic is_commit;
      logic is_lookup;
      logic perm_zero;
      logic active_empty;
      logic search_open;
      logic hit;
      logic full;
      logic shift_more;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

FILE: src/iptl_ram.sv
// ----------------------------------------------------------------------------
// iptl_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iptl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/iptl_ctrl.sv
// ----------------------------------------------------------------------------
// iptl_ctrl: sequencing state machine
// Steps one request through decode, binary search, sorted-insert shift
// and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iptl_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire iptl_pkg::stat_type stat,
   output      iptl_pkg::cmd_type  cmd
);

   import iptl_pkg::*;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= K_NOP;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            priority if (stat.is_insert) begin
               if (stat.perm_zero) begin
                  kind_in  = K_REJECT;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SRCH_RD;
               end
            end else if (stat.is_commit) begin
               kind_in  = K_COMMIT;
               state_in = S_FINISH;
            end else if (stat.is_lookup) begin
               if (stat.active_empty) begin
                  kind_in  = K_EMPTY;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SRCH_RD;
               end
            end else begin
               kind_in  = K_NOP;
               state_in = S_FINISH;
            end
         end
         S_SRCH_RD: begin
            state_in = stat.search_open ? S_SRCH_CMP : S_MISSED;
         end
         S_SRCH_CMP: begin
            if (stat.hit) begin
               kind_in  = stat.is_insert ? K_INS_MERGE : K_HIT;
               state_in = S_FINISH;
            end else begin
               state_in = S_SRCH_RD;
            end
         end
         S_MISSED: begin
            priority if (!stat.is_insert) begin
               kind_in  = K_MISS;
               state_in = S_FINISH;
            end else if (stat.full) begin
               kind_in  = K_FULL;
               state_in = S_FINISH;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            if (stat.shift_more) begin
               state_in = S_SHIFT_WR;
            end else begin
               kind_in  = K_INS_NEW;
               state_in = S_FINISH;
            end
         end
         S_SHIFT_WR: state_in = S_SHIFT_RD;
         S_FINISH: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.kind  = kind_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         S_SRCH_RD:  cmd.rd_mid   = stat.search_open;
         S_SRCH_CMP: cmd.step     = !stat.hit;
         S_SHIFT_RD: cmd.rd_shift = stat.shift_more;
         S_SHIFT_WR: cmd.wr_shift = 1'b1;
         S_FINISH:   cmd.finish   = stat.out_free;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

FILE: src/iptl_datapath.sv
// ----------------------------------------------------------------------------
// iptl_datapath: table storage, search bounds, counts and result register
// Two banks in one RAM; shadow bank kept sorted on insert.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iptl_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire iptl_pkg::req_type req_payload,
   input  wire iptl_pkg::cmd_type cmd,
   output      iptl_pkg::stat_type stat,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      iptl_pkg::rsp_type rsp_payload
);

   import iptl_pkg::*;

   req_type          req_ff;
   logic             bank_sel_ff;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic             active_bank_ff, active_bank_in;
   logic [CNT_W-1:0] active_count_ff, active_count_in;
   logic [CNT_W-1:0] shadow_count_ff, shadow_count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [CNT_W:0]    mid_sum;
   logic [CNT_W-1:0]  mid;
   logic [CNT_W-1:0]  jm1;
   logic              shadow_bank;
   logic              rd_en, wr_en;
   logic [MEM_AW-1:0] rd_addr, wr_addr;
   entry_type         rd_data, wr_data;
   logic              is_insert;

   assign shadow_bank = ~active_bank_ff;
   assign mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid         = mid_sum[CNT_W:1];
   assign jm1         = j_ff - CNT_W'(1);
   assign is_insert   = (req_ff.opcode == OP_INSERT);

   // memory ports
   always_comb begin
      rd_en   = cmd.rd_mid | cmd.rd_shift;
      rd_addr = cmd.rd_mid ? {bank_sel_ff, mid[IDX_W-1:0]} : {shadow_bank, jm1[IDX_W-1:0]};
      wr_en   = 1'b0;
      wr_addr = {shadow_bank, j_ff[IDX_W-1:0]};
      wr_data = rd_data;
      if (cmd.wr_shift) begin
         wr_en = 1'b1;
      end else if (cmd.finish && cmd.kind == K_INS_NEW) begin
         wr_en        = 1'b1;
         wr_addr      = {shadow_bank, lo_ff[IDX_W-1:0]};
         wr_data.addr = req_ff.ip_address;
         wr_data.perm = req_ff.permission_bits;
      end else if (cmd.finish && cmd.kind == K_INS_MERGE) begin
         wr_en        = 1'b1;
         wr_addr      = {shadow_bank, mid[IDX_W-1:0]};
         wr_data.perm = rd_data.perm | req_ff.permission_bits;
      end
   end

   iptl_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(MEM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // search bounds and shift pointer
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      j_in  = j_ff;
      if (cmd.load) begin
         lo_in = '0;
         hi_in = (req_payload.opcode == OP_INSERT) ? shadow_count_ff : active_count_ff;
         j_in  = shadow_count_ff;
      end else if (cmd.step) begin
         if (rd_data.addr < req_ff.ip_address) lo_in = mid + CNT_W'(1);
         else hi_in = mid;
      end else if (cmd.wr_shift) begin
         j_in = jm1;
      end
   end

   // table state and result
   always_comb begin
      active_bank_in  = active_bank_ff;
      active_count_in = active_count_ff;
      shadow_count_in = shadow_count_ff;
      if (cmd.finish && cmd.kind == K_INS_NEW) begin
         shadow_count_in = shadow_count_ff + CNT_W'(1);
      end else if (cmd.finish && cmd.kind == K_COMMIT) begin
         active_bank_in  = shadow_bank;
         active_count_in = shadow_count_ff;
         shadow_count_in = '0;
      end

      rsp_in         = rsp_ff;
      rsp_in.status  = ST_OK;
      rsp_in.granted = '0;
      unique case (cmd.kind)
         K_FULL:   rsp_in.status  = ST_FULL;
         K_REJECT: rsp_in.status  = ST_REJECT;
         K_MISS:   rsp_in.status  = ST_MISS;
         K_HIT:    rsp_in.granted = rd_data.perm;
         K_EMPTY:  rsp_in.granted = PERM_RW;
         default: ;
      endcase
      rsp_in.entry_count = COUNT_W'(is_insert ? shadow_count_in : active_count_in);

      rsp_valid_in = cmd.finish | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_bank_ff  <= 1'b1;
         active_count_ff <= '0;
         shadow_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         active_bank_ff  <= active_bank_in;
         active_count_ff <= active_count_in;
         shadow_count_ff <= shadow_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      j_ff  <= j_in;
      if (cmd.load) begin
         req_ff      <= req_payload;
         bank_sel_ff <= (req_payload.opcode == OP_INSERT) ? shadow_bank : active_bank_ff;
      end
      if (cmd.finish) rsp_ff <= rsp_in;
   end

   always_comb begin
      stat              = '0;
      stat.is_insert    = is_insert;
      stat.is_commit    = (req_ff.opcode == OP_COMMIT);
      stat.is_lookup    = (req_ff.opcode == OP_LOOKUP);
      stat.perm_zero    = (req_ff.permission_bits == 3'b000);
      stat.active_empty = (active_count_ff == '0);
      stat.search_open  = (lo_ff < hi_ff);
      stat.hit          = (rd_data.addr == req_ff.ip_address);
      stat.full         = (shadow_count_ff >= CNT_W'(ENTRIES));
      stat.shift_more   = (j_ff > lo_ff);
      stat.out_free     = ~rsp_valid_ff | ~rsp_stall;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

FILE: src/ip_permission_table_lookup_unit.sv
// ----------------------------------------------------------------------------
// ip_permission_table_lookup_unit: double-buffered IPv4 permission table
// Top level joining the sequencing FSM and the table datapath.
// ----------------------------------------------------------------------------
// One request at a time. Insert goes to the shadow bank, which is kept sorted
// by address: a binary search (each probe a read state, one RAM read, then a
// compare state) finds a duplicate to merge or the insert point, then entries
// above it move up one slot each, read then written. Commit swaps banks.
// Lookup is a binary search of the active bank. The table RAM has a single
// read port. An empty active table grants read and write. A finished
// response waits in an output register while the next request is taken. No
// clearing pass after reset: only written entries are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ip_permission_table_lookup_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire iptl_pkg::req_type req_payload,
   // response channel
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      iptl_pkg::rsp_type rsp_payload
);

   import iptl_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // controller: decides which step runs each cycle
   iptl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: RAM, bounds, counts, response register
   iptl_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: src/iptl_checker.sv
// ----------------------------------------------------------------------------
// iptl_checker: port-level checks for the permission table
// Watches handshakes and response consistency at the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iptl_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire iptl_pkg::rsp_type rsp_payload
);

   import iptl_pkg::*;

   // one request in flight: stall right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled response changed");

   // grants only come with ok status
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.granted != 3'b000) |-> (rsp_payload.status == ST_OK))
      else $error("grant with failing status");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.entry_count <= COUNT_W'(ENTRIES)))
      else $error("entry count out of range");

endmodule

bind ip_permission_table_lookup_unit iptl_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
